// File: rtl/vdh_pkg.sv
// shared constants, codes and types of the vertex degree histogram unit
`timescale 1ns / 1ps
package vdh_pkg;

   localparam int MAX_VERTICES_DEFAULT = 64;
   localparam int MAX_DEGREE_DEFAULT   = 63;

   localparam int OP_W      = 2;
   localparam int VERTEX_W  = 6;
   localparam int DEGREE_W  = 6;
   localparam int COUNT_W   = 7;
   localparam int VCOUNT_W  = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int REQ_PAD_W  = REQ_DATA_W - 2 * VERTEX_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - DEGREE_W - COUNT_W;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [OP_W-1:0] OP_REPORT   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

   typedef enum logic [1:0] {
      DEG_ADDR_IDX = 2'd0,
      DEG_ADDR_A   = 2'd1,
      DEG_ADDR_B   = 2'd2
   } vdh_deg_sel_type;

   typedef struct packed {
      logic            load_item;
      logic            idx_clr;
      logic            idx_inc;
      vdh_deg_sel_type deg_sel;
      logic            bump;
      logic            sweep_clr;
      logic            hist_from_deg;
      logic            hist_inc;
      logic            bin_step;
      logic            flush;
   } vdh_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic vertex_last;
      logic no_vertices;
      logic bin_last;
      logic bin_hold;
      logic pend_valid;
      logic out_free;
   } vdh_status_type;

endpackage

// File: rtl/vdh_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module vdh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/vdh_ctrl.sv
// sequencer for edge updates, clearing sweeps and histogram reports
`timescale 1ns / 1ps
module vdh_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [vdh_pkg::OP_W-1:0]      req_tuser,
   input  logic                          csr_valid,
   input  vdh_pkg::vdh_status_type       status,
   output vdh_pkg::vdh_cmd_type          cmd
);
   import vdh_pkg::*;

   typedef enum logic [11:0] {
      ST_CLEAR   = 12'b0000_0000_0001,
      ST_IDLE    = 12'b0000_0000_0010,
      ST_EA_RD   = 12'b0000_0000_0100,
      ST_EA_WR   = 12'b0000_0000_1000,
      ST_EB_RD   = 12'b0000_0001_0000,
      ST_EB_WR   = 12'b0000_0010_0000,
      ST_CNT_RD  = 12'b0000_0100_0000,
      ST_CNT_BIN = 12'b0000_1000_0000,
      ST_CNT_WR  = 12'b0001_0000_0000,
      ST_EM_RD   = 12'b0010_0000_0000,
      ST_EM_CHK  = 12'b0100_0000_0000,
      ST_EM_FIN  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.deg_sel = DEG_ADDR_IDX;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_clr = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               case (req_tuser)
                  OP_ADD_EDGE: state_in = ST_EA_RD;
                  OP_REPORT: begin
                     cmd.idx_clr = 1'b1;
                     state_in = status.no_vertices ? ST_EM_RD : ST_CNT_RD;
                  end
                  OP_CLEAR: begin
                     cmd.idx_clr = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EA_RD: begin
            cmd.deg_sel = DEG_ADDR_A;
            state_in = ST_EA_WR;
         end
         ST_EA_WR: begin
            cmd.deg_sel = DEG_ADDR_A;
            cmd.bump = 1'b1;
            state_in = ST_EB_RD;
         end
         ST_EB_RD: begin
            cmd.deg_sel = DEG_ADDR_B;
            state_in = ST_EB_WR;
         end
         ST_EB_WR: begin
            cmd.deg_sel = DEG_ADDR_B;
            cmd.bump = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_BIN;
         end
         ST_CNT_BIN: begin
            cmd.hist_from_deg = 1'b1;
            state_in = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            cmd.hist_from_deg = 1'b1;
            cmd.hist_inc = 1'b1;
            if (status.vertex_last) begin
               cmd.idx_clr = 1'b1;
               state_in = ST_EM_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in = ST_CNT_RD;
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_CHK;
         end
         ST_EM_CHK: begin
            if (!status.bin_hold) begin
               cmd.bin_step = 1'b1;
               if (status.bin_last) begin
                  state_in = ST_EM_FIN;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in = ST_EM_RD;
               end
            end
         end
         ST_EM_FIN: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      // register write restarts the degree clearing sweep
      if (csr_valid) begin
         cmd = '0;
         cmd.deg_sel = DEG_ADDR_IDX;
         cmd.idx_clr = 1'b1;
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/vdh_datapath.sv
// degree and histogram memories, sweep counter, pending bin and result register
`timescale 1ns / 1ps
module vdh_datapath #(
   parameter int MAX_VERTICES = vdh_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_DEGREE   = vdh_pkg::MAX_DEGREE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  vdh_pkg::vdh_cmd_type                cmd,
   output vdh_pkg::vdh_status_type             status,
   input  logic [vdh_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                csr_valid,
   input  logic [vdh_pkg::VCOUNT_W-1:0]        csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vdh_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast
);
   import vdh_pkg::*;

   localparam int NUM_BINS = MAX_DEGREE + 1;
   localparam int SWEEP    = (MAX_VERTICES > NUM_BINS) ? MAX_VERTICES : NUM_BINS;
   localparam int IW       = $clog2(SWEEP + 1);
   localparam int AW       = $clog2(MAX_VERTICES);
   localparam int BW       = $clog2(NUM_BINS);
   localparam int HW       = $clog2(MAX_VERTICES + 1);

   logic [VERTEX_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [VCOUNT_W-1:0] vc_ff, vc_in;
   logic [BW-1:0]       pend_deg_ff, pend_deg_in;
   logic [HW-1:0]       pend_cnt_ff, pend_cnt_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]       rsp_deg_ff, rsp_deg_in;
   logic [HW-1:0]       rsp_cnt_ff, rsp_cnt_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [IW-1:0]       n_active;
   logic [VERTEX_W-1:0] endpoint;
   logic                endpoint_ok;
   logic [AW-1:0]       deg_rd_addr, deg_wr_addr;
   logic [BW-1:0]       deg_rd_data, deg_wr_data;
   logic                deg_we;
   logic [BW-1:0]       hist_rd_addr, hist_wr_addr;
   logic [HW-1:0]       hist_rd_data, hist_wr_data;
   logic                hist_we;
   logic                bin_nz, out_free, push;

   always_comb begin
      if (32'(vc_ff) > MAX_VERTICES) begin
         n_active = IW'(MAX_VERTICES);
      end else begin
         n_active = IW'(vc_ff);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign bin_nz   = (hist_rd_data != '0);

   always_comb begin
      status.sweep_last  = (idx_ff == IW'(SWEEP - 1));
      status.vertex_last = (idx_ff == n_active - IW'(1));
      status.no_vertices = (n_active == '0);
      status.bin_last    = (idx_ff == IW'(NUM_BINS - 1));
      status.bin_hold    = bin_nz && pend_valid_ff && !out_free;
      status.pend_valid  = pend_valid_ff;
      status.out_free    = out_free;
   end

   // degree memory addressing
   always_comb begin
      case (cmd.deg_sel)
         DEG_ADDR_A: endpoint = a_ff;
         DEG_ADDR_B: endpoint = b_ff;
         default:    endpoint = a_ff;
      endcase
      endpoint_ok = (32'(endpoint) < 32'(n_active));
      case (cmd.deg_sel)
         DEG_ADDR_A, DEG_ADDR_B: deg_rd_addr = AW'(endpoint);
         default:                deg_rd_addr = AW'(idx_ff);
      endcase
      if (cmd.sweep_clr) begin
         deg_wr_addr = AW'(idx_ff);
         deg_wr_data = '0;
         deg_we      = (32'(idx_ff) < MAX_VERTICES);
      end else begin
         deg_wr_addr = deg_rd_addr;
         deg_wr_data = deg_rd_data + BW'(1);
         deg_we      = cmd.bump && endpoint_ok && (deg_rd_data < BW'(MAX_DEGREE));
      end
   end

   // histogram memory addressing
   always_comb begin
      hist_rd_addr = cmd.hist_from_deg ? deg_rd_data : BW'(idx_ff);
      hist_wr_addr = hist_rd_addr;
      hist_wr_data = '0;
      hist_we      = 1'b0;
      if (cmd.sweep_clr) begin
         hist_wr_addr = BW'(idx_ff);
         hist_we      = (32'(idx_ff) < NUM_BINS);
      end else if (cmd.hist_inc) begin
         hist_wr_data = hist_rd_data + HW'(1);
         hist_we      = 1'b1;
      end else if (cmd.bin_step) begin
         hist_we      = 1'b1;
      end
   end

   vdh_ram #(
      .WIDTH (BW),
      .DEPTH (MAX_VERTICES)
   ) u_degree_ram (
      .clock   (clock),
      .wr_en   (deg_we),
      .wr_addr (deg_wr_addr),
      .wr_data (deg_wr_data),
      .rd_addr (deg_rd_addr),
      .rd_data (deg_rd_data)
   );

   vdh_ram #(
      .WIDTH (HW),
      .DEPTH (NUM_BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   always_comb begin
      a_in          = cmd.load_item ? req_tdata[VERTEX_W-1:0] : a_ff;
      b_in          = cmd.load_item ? req_tdata[2*VERTEX_W-1:VERTEX_W] : b_ff;
      vc_in         = csr_valid ? csr_data : vc_ff;
      idx_in        = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IW'(1);
      end
      pend_deg_in   = pend_deg_ff;
      pend_cnt_in   = pend_cnt_ff;
      pend_valid_in = pend_valid_ff;
      push          = 1'b0;
      rsp_deg_in    = rsp_deg_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.bin_step && bin_nz) begin
         pend_deg_in   = BW'(idx_ff);
         pend_cnt_in   = hist_rd_data;
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            push        = 1'b1;
            rsp_last_in = 1'b0;
         end
      end
      if (cmd.flush) begin
         pend_valid_in = 1'b0;
         push          = 1'b1;
         rsp_last_in   = 1'b1;
      end
      if (push) begin
         rsp_deg_in = pend_deg_ff;
         rsp_cnt_in = pend_cnt_ff;
      end
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         vc_ff         <= VCOUNT_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         vc_ff         <= vc_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      pend_deg_ff <= pend_deg_in;
      pend_cnt_ff <= pend_cnt_in;
      rsp_deg_ff  <= rsp_deg_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, COUNT_W'(rsp_cnt_ff), DEGREE_W'(rsp_deg_ff)};

endmodule

// File: rtl/vertex_degree_histogram_unit.sv
// top level of the vertex degree histogram unit
//
//   channel  | signals                              | content
//   ---------+--------------------------------------+------------------------------------
//   req      | req_tvalid req_tready req_tdata/user | tuser op; tdata vertex_a, vertex_b
//   rsp      | rsp_tvalid rsp_tready rsp_tdata/last | tdata degree, vertices_with_degree
//   csr      | csr_valid csr_ready csr_data         | vertex_count
//
// an edge request is accepted, then runs two read-modify-writes of the degree ram
// a report reads the degree of each active vertex and bumps its bin in the histogram ram,
// then steps through every bin, and stalls while rsp_tready is held low
// reset, a clear request and a csr write run a clearing sweep of
// max(MAX_VERTICES, MAX_DEGREE+1) entries, 64 by default, with req_tready low
// the result register lets the next request in while the final result still waits
`timescale 1ns / 1ps
module vertex_degree_histogram_unit #(
   parameter int MAX_VERTICES = vdh_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_DEGREE   = vdh_pkg::MAX_DEGREE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [vdh_pkg::REQ_DATA_W-1:0]   req_tdata,   // vertex_a, vertex_b
   input  logic [vdh_pkg::OP_W-1:0]         req_tuser,   // op
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [vdh_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // degree, vertices_with_degree
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vdh_pkg::VCOUNT_W-1:0]     csr_data
);
   import vdh_pkg::*;

   vdh_cmd_type    cmd;
   vdh_status_type status;

   assign csr_ready = 1'b1;

   vdh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .status     (status),
      .cmd        (cmd)
   );

   vdh_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_DEGREE   (MAX_DEGREE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/vertex_degree_histogram_unit_tb.sv
// testbench of the vertex degree histogram unit: directed table, then random phases
`timescale 1ns / 1ps
module vertex_degree_histogram_unit_tb;
   import vdh_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int NUM_VERTICES = MAX_VERTICES_DEFAULT;
   localparam int NUM_BINS     = MAX_DEGREE_DEFAULT + 1;
   localparam int DRAIN_CYCLES = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int NUM_PHASES   = 8;
   localparam int NUM_ROWS     = 24;

   typedef enum logic {
      ROW_ITEM,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [VCOUNT_W-1:0] csr_value;
      logic [OP_W-1:0]     op;
      logic [VERTEX_W-1:0] va;
      logic [VERTEX_W-1:0] vb;
      logic                fixed;
      logic [DEGREE_W-1:0] fixed_degree;
      logic [COUNT_W-1:0]  fixed_count;
   } stim_row_type;

   typedef struct packed {
      logic [DEGREE_W-1:0] degree;
      logic [COUNT_W-1:0]  vcnt;
      logic                last;
   } bin_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [OP_W-1:0]         req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [VCOUNT_W-1:0]     csr_data = '0;

   logic [DEGREE_W-1:0] vertex_degree [NUM_VERTICES];
   logic [VCOUNT_W-1:0] vertex_count_reg;
   bin_result_type      pending_bins [$];
   int                  mismatch_count = 0;
   int                  stall_cycles = 0;
   int                  req_idle_pct = 9;
   int                  rsp_idle_pct = 81;

   stim_row_type stim_table [NUM_ROWS] = '{
      '{ROW_ITEM, 7'd0,   OP_REPORT,   6'd0,  6'd0,  1'b1, 6'd0, 7'd64},
      '{ROW_ITEM, 7'd0,   OP_ADD_EDGE, 6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_ADD_EDGE, 6'd63, 6'd63, 1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_ADD_EDGE, 6'd0,  6'd63, 1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_UNUSED,   6'd63, 6'd63, 1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_REPORT,   6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_CLEAR,    6'd63, 6'd63, 1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_REPORT,   6'd63, 6'd63, 1'b1, 6'd0, 7'd64},
      '{ROW_ITEM, 7'd0,   OP_ADD_EDGE, 6'd21, 6'd42, 1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_ADD_EDGE, 6'd42, 6'd21, 1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_REPORT,   6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_CSR,  7'd1,   OP_ADD_EDGE, 6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_ADD_EDGE, 6'd0,  6'd63, 1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_ADD_EDGE, 6'd63, 6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_ADD_EDGE, 6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_REPORT,   6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_CSR,  7'd0,   OP_ADD_EDGE, 6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_ADD_EDGE, 6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_REPORT,   6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_CSR,  7'd127, OP_ADD_EDGE, 6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_REPORT,   6'd0,  6'd0,  1'b1, 6'd0, 7'd64},
      '{ROW_ITEM, 7'd0,   OP_ADD_EDGE, 6'd63, 6'd62, 1'b0, 6'd0, 7'd0},
      '{ROW_ITEM, 7'd0,   OP_REPORT,   6'd0,  6'd0,  1'b0, 6'd0, 7'd0},
      '{ROW_CSR,  7'd64,  OP_ADD_EDGE, 6'd0,  6'd0,  1'b0, 6'd0, 7'd0}
   };

   logic [VCOUNT_W-1:0] phase_vcount [NUM_PHASES] = '{
      7'd1, 7'd2, 7'd64, 7'd127, 7'd0, 7'd2, 7'd1, 7'd64
   };

   vertex_degree_histogram_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic int active_vertices();
      return (vertex_count_reg > NUM_VERTICES) ? NUM_VERTICES : int'(vertex_count_reg);
   endfunction

   task automatic bump_degree(input logic [VERTEX_W-1:0] v);
      if (int'(v) < active_vertices() && vertex_degree[v] < MAX_DEGREE_DEFAULT) begin
         vertex_degree[v] = vertex_degree[v] + 1'b1;
      end
   endtask

   task automatic clear_degrees();
      foreach (vertex_degree[v]) vertex_degree[v] = '0;
   endtask

   // update the degree model and queue the expected histogram bins for one request
   task automatic predict_request(input logic [OP_W-1:0] op,
                                  input logic [VERTEX_W-1:0] va,
                                  input logic [VERTEX_W-1:0] vb);
      int             bin_tally [NUM_BINS];
      int             top;
      bin_result_type bin;
      top = -1;
      case (op)
         OP_ADD_EDGE: begin
            bump_degree(va);
            bump_degree(vb);
         end
         OP_REPORT: begin
            foreach (bin_tally[d]) bin_tally[d] = 0;
            for (int v = 0; v < active_vertices(); v++) begin
               bin_tally[vertex_degree[v]]++;
            end
            foreach (bin_tally[d]) if (bin_tally[d] != 0) top = d;
            for (int d = 0; d < NUM_BINS; d++) begin
               if (bin_tally[d] != 0) begin
                  bin.degree = DEGREE_W'(d);
                  bin.vcnt   = COUNT_W'(bin_tally[d]);
                  bin.last   = (d == top);
                  pending_bins.push_back(bin);
               end
            end
         end
         OP_CLEAR: clear_degrees();
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic apply_request(input logic [OP_W-1:0] op,
                                input logic [VERTEX_W-1:0] va,
                                input logic [VERTEX_W-1:0] vb,
                                input logic fixed,
                                input logic [DEGREE_W-1:0] fixed_degree,
                                input logic [COUNT_W-1:0] fixed_count);
      bin_result_type bin;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, vb, va};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (fixed) begin
         bin.degree = fixed_degree;
         bin.vcnt   = fixed_count;
         bin.last   = 1'b1;
         pending_bins.push_back(bin);
      end else begin
         predict_request(op, va, vb);
      end
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_bins.size() != 0) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      vertex_count_reg = value;
      clear_degrees();
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin : rsp_check
      bin_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bins.size() == 0) begin
            report_mismatch("unexpected request result", int'(rsp_tdata), 0);
         end else begin
            want = pending_bins.pop_front();
            if (rsp_tdata[DEGREE_W-1:0] !== want.degree)
               report_mismatch("degree", int'(rsp_tdata[DEGREE_W-1:0]), int'(want.degree));
            if (rsp_tdata[DEGREE_W +: COUNT_W] !== want.vcnt)
               report_mismatch("vertex count", int'(rsp_tdata[DEGREE_W +: COUNT_W]),
                               int'(want.vcnt));
            if (rsp_tlast !== want.last)
               report_mismatch("last flag", int'(rsp_tlast), int'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                  eff;
      int                  n_items;
      int                  pick;
      logic [VCOUNT_W-1:0] vc;
      logic [OP_W-1:0]     op;
      logic [VERTEX_W-1:0] va;
      logic [VERTEX_W-1:0] vb;
      vertex_count_reg = VCOUNT_RESET;
      clear_degrees();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (stim_table[r]) begin
         if (stim_table[r].kind == ROW_CSR) begin
            write_vertex_count(stim_table[r].csr_value);
         end else begin
            apply_request(stim_table[r].op, stim_table[r].va, stim_table[r].vb,
                          stim_table[r].fixed, stim_table[r].fixed_degree,
                          stim_table[r].fixed_count);
         end
      end

      // random phases
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < 3) begin
            req_idle_pct = 9;
            rsp_idle_pct = 81;
         end else if (p < 6) begin
            req_idle_pct = 81;
            rsp_idle_pct = 9;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         vc = (p == 1 || p == 5) ? VCOUNT_W'($urandom_range(2, 63)) : phase_vcount[p];
         write_vertex_count(vc);
         eff = active_vertices();
         n_items = (eff <= 2) ? 50 : 30;
         for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) wait_results_drained();
            pick = $urandom_range(0, 99);
            if (pick < 8) op = OP_REPORT;
            else if (pick < 11) op = OP_CLEAR;
            else if (pick < 14) op = OP_UNUSED;
            else op = OP_ADD_EDGE;
            va = VERTEX_W'($urandom_range(0, 63));
            vb = VERTEX_W'($urandom_range(0, 63));
            if (op == OP_ADD_EDGE && eff > 0) begin
               if ($urandom_range(0, 9) < 9) va = VERTEX_W'($urandom_range(0, eff - 1));
               if ($urandom_range(0, 9) < 9) vb = VERTEX_W'($urandom_range(0, eff - 1));
               if ($urandom_range(0, 9) == 0) vb = va;
            end
            apply_request(op, va, vb, 1'b0, '0, '0);
         end
         apply_request(OP_REPORT, VERTEX_W'($urandom), VERTEX_W'($urandom), 1'b0, '0, '0);
      end

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
